FILE: src/bucketed_hash_set_top_macros.svh
// assertion macros for the bucketed hash set checker
`ifndef BUCKETED_HASH_SET_TOP_MACROS_SVH
`define BUCKETED_HASH_SET_TOP_MACROS_SVH

// clocked property with asynchronous reset disable
`define BHS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on the next cycle
`define BHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/bhs_pkg.sv
// shared types and constants for the bucketed hash set
package bhs_pkg;

	localparam int KEY_W       = 31;
	localparam int CMD_W       = 2;
	localparam int BUCKETS_DEF = 1024;
	localparam int WAYS_DEF    = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD      = 2'd0,
		CMD_REMOVE   = 2'd1,
		CMD_CONTAINS = 2'd2
	} cmd_t;

endpackage

FILE: src/bucketed_hash_set_top.sv
// bucketed hash set: reciprocal remainder unit, bucket memories and result register
// flow: an input transfer passes through a multiply, a remainder correction, a memory
//   read and a compare and update before the result is valid
// one request is in flight at a time; a stalled result holds the next request in the
//   compare stage and keeps in_ready low
// reset: arst_n clears control state; then a clearing pass over all BUCKETS entries
//   zeroes the valid memory, with in_ready low; stored keys are not cleared
module bucketed_hash_set_top
	import bhs_pkg::*;
#(
	parameter int BUCKETS = BUCKETS_DEF,
	parameter int WAYS    = WAYS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CMD_W-1:0] cmd,
	input  logic [KEY_W-1:0] key,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             present,
	output logic             full_res
);

	localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int REM_W   = BKT_W + 1;
	localparam int RECIP_W = 32;
	localparam int PROD_W  = KEY_W + RECIP_W;
	localparam logic [REM_W-1:0]   BKT_VAL  = REM_W'(BUCKETS);
	localparam logic [BKT_W-1:0]   BKT_LAST = BKT_W'(BUCKETS - 1);
	localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(64'hFFFF_FFFF / 64'(BUCKETS));

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_REM,
		S_READ,
		S_EVAL
	} state_t;

	typedef logic [WAYS-1:0][KEY_W-1:0] key_row_t;

	state_t            state_q;
	logic [BKT_W-1:0]  clr_cnt_q;
	logic [REM_W-1:0]  quot_q;
	logic [BKT_W-1:0]  rem_q;
	logic [PROD_W-1:0] prod;
	logic [REM_W-1:0]  qd;
	logic [REM_W-1:0]  rem_raw;
	logic [REM_W-1:0]  rem_fix;
	logic [KEY_W-1:0]  key_q;
	logic [CMD_W-1:0]  cmd_q;
	logic              out_valid_q;
	logic              present_q;
	logic              full_q;

	logic [WAYS-1:0]   valid_mem [BUCKETS];
	key_row_t          key_mem [BUCKETS];
	logic [WAYS-1:0]   vld_rdata_q;
	key_row_t          key_rdata_q;

	logic [BKT_W-1:0]  bkt;
	logic              rd_en;
	logic              vld_we;
	logic [BKT_W-1:0]  vld_addr;
	logic [WAYS-1:0]   vld_wdata;
	logic              key_we;
	key_row_t          key_wdata;
	logic [WAYS-1:0]   hit_vec;
	logic              hit_any;
	logic [WAYS-1:0]   free_oh;
	logic              free_any;
	logic              do_insert;
	logic              do_remove;
	logic              is_add;
	logic              out_free;
	logic              eval_fire;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign present   = present_q;
	assign full_res  = full_q;

	// quotient estimate by reciprocal, short by at most one
	assign prod = PROD_W'(key_q) * PROD_W'(RECIP);

	// remainder from the low bits only, then one correction step
	assign qd      = quot_q * BKT_VAL;
	assign rem_raw = key_q[REM_W-1:0] - qd;
	assign rem_fix = (rem_raw >= BKT_VAL) ? (rem_raw - BKT_VAL) : rem_raw;

	assign bkt   = rem_q;
	assign rd_en = (state_q == S_READ);

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w] = vld_rdata_q[w] && (key_rdata_q[w] == key_q);
		end
	end

	assign hit_any   = |hit_vec;
	assign free_oh   = ~vld_rdata_q & (vld_rdata_q + WAYS'(1));
	assign free_any  = ~&vld_rdata_q;
	assign is_add    = (cmd_q == CMD_ADD);
	assign do_insert = is_add && !hit_any && free_any;
	assign do_remove = (cmd_q == CMD_REMOVE) && hit_any;
	assign out_free  = !out_valid_q || out_ready;
	assign eval_fire = (state_q == S_EVAL) && out_free;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			key_wdata[w] = free_oh[w] ? key_q : key_rdata_q[w];
		end
	end

	always_comb begin
		vld_we    = 1'b0;
		vld_addr  = bkt;
		vld_wdata = vld_rdata_q;
		key_we    = 1'b0;
		if (state_q == S_CLEAR) begin
			vld_we    = 1'b1;
			vld_addr  = clr_cnt_q;
			vld_wdata = '0;
		end else if (eval_fire) begin
			if (do_insert) begin
				vld_we    = 1'b1;
				vld_wdata = vld_rdata_q | free_oh;
				key_we    = 1'b1;
			end else if (do_remove) begin
				vld_we    = 1'b1;
				vld_wdata = vld_rdata_q & ~hit_vec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_we) begin
			valid_mem[vld_addr] <= vld_wdata;
		end
		if (rd_en) begin
			vld_rdata_q <= valid_mem[bkt];
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[bkt] <= key_wdata;
		end
		if (rd_en) begin
			key_rdata_q <= key_mem[bkt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			quot_q      <= '0;
			rem_q       <= '0;
			key_q       <= '0;
			cmd_q       <= '0;
			out_valid_q <= 1'b0;
			present_q   <= 1'b0;
			full_q      <= 1'b0;
		end else begin
			if (eval_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + BKT_W'(1);
					if (clr_cnt_q == BKT_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						key_q   <= key;
						cmd_q   <= cmd;
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					quot_q  <= prod[RECIP_W +: REM_W];
					state_q <= S_REM;
				end
				S_REM: begin
					rem_q   <= rem_fix[BKT_W-1:0];
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (out_free) begin
						present_q <= hit_any;
						full_q    <= is_add && !hit_any && !free_any;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/bhs_checker.sv
// port-level checker for the bucketed hash set, bound to the top level
`include "bucketed_hash_set_top_macros.svh"

module bhs_port_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic present,
	input logic full_res
);

	// stalled result holds
	`BHS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(present) && $stable(full_res), "stalled result changed")

	// a dropped add never reports a present key
	`BHS_ASSERT(a_full_not_present, clk, arst_n, out_valid |-> !(present && full_res), "full and present together")

	// one request in flight: ready drops after a transfer
	`BHS_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready, "ready held after input transfer")

	// a new result rises only if in_ready was low just before it, while a request was pending
	`BHS_ASSERT(a_result_after_work, clk, arst_n, $rose(out_valid) |-> !$past(in_ready), "result without pending request")

endmodule

bind bucketed_hash_set_top bhs_port_checker u_bhs_checker (.*);
